// ----- hw/rtl/rsq_pkg.sv -----
// Shared constants and float helper functions for the reciprocal square root pipeline.
`timescale 1ns / 1ps
package rsq_pkg;

   localparam logic [31:0] RSQ_MAGIC        = 32'h5F37_59DF;
   localparam logic [31:0] RSQ_HALF         = 32'h3F00_0000;
   localparam logic [31:0] RSQ_THREE_HALVES = 32'h3FC0_0000;
   localparam logic [31:0] RSQ_QNAN         = 32'h7FC0_0000;
   localparam logic [30:0] RSQ_INF_MAG      = 31'h7F80_0000;

   // Pipeline depths.
   localparam int MUL_STAGES = 3;
   localparam int ADD_STAGES = 4;
   localparam int PIPE_DEPTH = 4 * MUL_STAGES + ADD_STAGES;

   // Early-out result for NaN / inf / zero operands.
   typedef struct packed {
      logic        hit;
      logic [31:0] val;
   } rsq_spec_type;

   function automatic logic f_isnan(logic [31:0] x);
      return x[30:0] > RSQ_INF_MAG;
   endfunction

   function automatic logic f_isinf(logic [31:0] x);
      return x[30:0] == RSQ_INF_MAG;
   endfunction

   function automatic logic f_iszero(logic [31:0] x);
      return x[30:0] == 31'd0;
   endfunction

   // Leading zero count, 24 bits.
   function automatic logic [4:0] clz24(logic [23:0] v);
      logic [4:0] n;
      n = 5'd24;
      for (int i = 0; i < 24; i++) begin
         if (v[i]) begin
            n = 5'(23 - i);
         end
      end
      return n;
   endfunction

   // Leading zero count, 28 bits.
   function automatic logic [4:0] clz28(logic [27:0] v);
      logic [4:0] n;
      n = 5'd28;
      for (int i = 0; i < 28; i++) begin
         if (v[i]) begin
            n = 5'(27 - i);
         end
      end
      return n;
   endfunction

   // Round m (leading one at bit 47) with biased exponent be to single, RNE.
   // Handles gradual underflow and overflow to infinity.
   function automatic logic [31:0] rsq_round(logic s, logic signed [10:0] be,
                                            logic [47:0] m);
      logic signed [10:0] shw;
      logic signed [10:0] bo;
      logic [4:0]         sh;
      logic [73:0]        w;
      logic [24:0]        q;
      logic               g;
      logic               st;
      logic [31:0]        r;
      shw = 11'sd1 - be;
      if (be >= 11'sd1) begin
         sh = 5'd0;
      end else if (shw > 11'sd26) begin
         sh = 5'd26;
      end else begin
         sh = shw[4:0];
      end
      w  = {m, 26'd0} >> sh;
      q  = {1'b0, w[73:50]};
      g  = w[49];
      st = |w[48:0];
      q  = q + 25'(g & (st | q[0]));
      bo = be;
      if (be >= 11'sd1) begin
         if (q[24]) begin
            q  = q >> 1;
            bo = be + 11'sd1;
         end
         if (bo >= 11'sd255) begin
            r = {s, RSQ_INF_MAG};
         end else begin
            r = {s, bo[7:0], q[22:0]};
         end
      end else begin
         r = {s, 7'd0, q[23:0]};
      end
      return r;
   endfunction

endpackage

// ----- hw/rtl/rsq_fmul.sv -----
// Three-stage single-precision multiplier: unpack, multiply, round.
`timescale 1ns / 1ps
module rsq_fmul (
   input  logic        clock,
   input  logic        en,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [31:0] p
);
   import rsq_pkg::*;

   // stage 1
   rsq_spec_type       s1_spec_ff, s1_spec_in;
   logic               s1_sign_ff, s1_sign_in;
   logic signed [10:0] s1_exp_ff, s1_exp_in;
   logic [23:0]        s1_ma_ff, s1_ma_in, s1_mb_ff, s1_mb_in;
   // stage 2
   rsq_spec_type       s2_spec_ff;
   logic               s2_sign_ff;
   logic signed [10:0] s2_exp_ff;
   logic [47:0]        s2_prod_ff, s2_prod_in;
   // stage 3
   logic [31:0]        s3_res_ff, s3_res_in;

   logic [7:0]  eba, ebb;
   logic [23:0] ma, mb;
   logic [4:0]  la, lb;
   logic        sgn;

   always_comb begin
      sgn = a[31] ^ b[31];
      eba = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
      ebb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
      ma  = {(a[30:23] != 8'd0), a[22:0]};
      mb  = {(b[30:23] != 8'd0), b[22:0]};
      la  = clz24(ma);
      lb  = clz24(mb);
      s1_ma_in   = ma << la;
      s1_mb_in   = mb << lb;
      s1_exp_in  = $signed(11'(eba)) + $signed(11'(ebb)) - $signed(11'(la))
                   - $signed(11'(lb));
      s1_sign_in = sgn;
      s1_spec_in = '{hit: 1'b0, val: 32'd0};
      if (f_isnan(a) || f_isnan(b)) begin
         s1_spec_in = '{hit: 1'b1, val: RSQ_QNAN};
      end else if (f_isinf(a) || f_isinf(b)) begin
         if (f_iszero(a) || f_iszero(b)) begin
            s1_spec_in = '{hit: 1'b1, val: RSQ_QNAN};
         end else begin
            s1_spec_in = '{hit: 1'b1, val: {sgn, RSQ_INF_MAG}};
         end
      end else if (f_iszero(a) || f_iszero(b)) begin
         s1_spec_in = '{hit: 1'b1, val: {sgn, 31'd0}};
      end
   end

   assign s2_prod_in = s1_ma_ff * s1_mb_ff;

   always_comb begin
      if (s2_spec_ff.hit) begin
         s3_res_in = s2_spec_ff.val;
      end else if (s2_prod_ff[47]) begin
         s3_res_in = rsq_round(s2_sign_ff, s2_exp_ff - 11'sd126, s2_prod_ff);
      end else begin
         s3_res_in = rsq_round(s2_sign_ff, s2_exp_ff - 11'sd127, s2_prod_ff << 1);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_spec_ff <= s1_spec_in;
         s1_sign_ff <= s1_sign_in;
         s1_exp_ff  <= s1_exp_in;
         s1_ma_ff   <= s1_ma_in;
         s1_mb_ff   <= s1_mb_in;
         s2_spec_ff <= s1_spec_ff;
         s2_sign_ff <= s1_sign_ff;
         s2_exp_ff  <= s1_exp_ff;
         s2_prod_ff <= s2_prod_in;
         s3_res_ff  <= s3_res_in;
      end
   end

   assign p = s3_res_ff;

endmodule

// ----- hw/rtl/fast_inverse_sqrt_float32.sv -----
// Top level: pipelined fast reciprocal square root on single-precision patterns.
// Datapath: four multipliers and one adder in series from the req transaction to rsp_tvalid.
// Throughput: one transaction per cycle while the output is not stalled; every stage is a register, no shared unit.
// Flow control: the whole pipe advances when the output register is empty or taken.
// Reset: synchronous, active high; clears the valid bits only, data registers are free.
`timescale 1ns / 1ps
module fast_inverse_sqrt_float32 (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] number_bits
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [31:0] result_bits
);
   import rsq_pkg::*;

   // Pipe enable: global stall when the result register is held.
   // No transaction is taken while reset is high.
   logic en;
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en && !reset;

   // Valid bits travel alongside the data.
   logic [PIPE_DEPTH-1:0] vld_ff, vld_in;
   assign vld_in = {vld_ff[PIPE_DEPTH-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   assign rsp_tvalid = vld_ff[PIPE_DEPTH-1];

   // Bit-trick first guess, carried along until the final multiply.
   localparam int YD = 3 * MUL_STAGES + ADD_STAGES;
   logic [31:0] y_guess;
   logic [31:0] y_ff [YD];

   assign y_guess = RSQ_MAGIC - {req_tdata[31], req_tdata[31:1]};

   always_ff @(posedge clock) begin
      if (en) begin
         y_ff[0] <= y_guess;
         for (int i = 1; i < YD; i++) begin
            y_ff[i] <= y_ff[i-1];
         end
      end
   end

   // half_x = x * 0.5
   logic [31:0] half_x, t1, t2, u;

   rsq_fmul u_mul_half (.clock(clock), .en(en), .a(req_tdata), .b(RSQ_HALF), .p(half_x));
   rsq_fmul u_mul_t1 (.clock(clock), .en(en), .a(half_x), .b(y_ff[MUL_STAGES-1]), .p(t1));
   rsq_fmul u_mul_t2 (.clock(clock), .en(en), .a(t1), .b(y_ff[2*MUL_STAGES-1]), .p(t2));

   // ---------------------------------------------------------------
   // u = 1.5 - t2, four stages: align, add, normalize, round.
   // ---------------------------------------------------------------
   logic [31:0] fa, fb;
   assign fa = RSQ_THREE_HALVES;
   assign fb = {~t2[31], t2[30:0]};

   // stage A1: specials, magnitude swap, alignment with sticky
   rsq_spec_type a1_spec_ff, a1_spec_in;
   logic         a1_sign_ff, a1_sign_in;
   logic         a1_sub_ff, a1_sub_in;
   logic [7:0]   a1_exp_ff, a1_exp_in;
   logic [26:0]  a1_big_ff, a1_big_in, a1_small_ff, a1_small_in;

   logic [31:0]  hi, lo;
   logic [7:0]   ebh, ebl, dexp;
   logic [23:0]  mh, ml;
   logic [53:0]  alw;

   always_comb begin
      if (fb[30:0] > fa[30:0]) begin
         hi = fb;
         lo = fa;
      end else begin
         hi = fa;
         lo = fb;
      end
      ebh  = (hi[30:23] == 8'd0) ? 8'd1 : hi[30:23];
      ebl  = (lo[30:23] == 8'd0) ? 8'd1 : lo[30:23];
      mh   = {(hi[30:23] != 8'd0), hi[22:0]};
      ml   = {(lo[30:23] != 8'd0), lo[22:0]};
      dexp = ebh - ebl;
      alw  = {ml, 3'd0, 27'd0} >> dexp[4:0];
      if (dexp >= 8'd27) begin
         a1_small_in = {26'd0, |ml};
      end else begin
         a1_small_in = {alw[53:28], alw[27] | (|alw[26:0])};
      end
      a1_big_in  = {mh, 3'd0};
      a1_exp_in  = ebh;
      a1_sign_in = hi[31];
      a1_sub_in  = hi[31] ^ lo[31];
      a1_spec_in = '{hit: 1'b0, val: 32'd0};
      if (f_isnan(fa) || f_isnan(fb)) begin
         a1_spec_in = '{hit: 1'b1, val: RSQ_QNAN};
      end else if (f_isinf(fa) && f_isinf(fb)) begin
         a1_spec_in = '{hit: 1'b1, val: (fa[31] == fb[31]) ? fa : RSQ_QNAN};
      end else if (f_isinf(fa)) begin
         a1_spec_in = '{hit: 1'b1, val: fa};
      end else if (f_isinf(fb)) begin
         a1_spec_in = '{hit: 1'b1, val: fb};
      end else if (f_iszero(fa) && f_iszero(fb)) begin
         a1_spec_in = '{hit: 1'b1, val: {fa[31] & fb[31], 31'd0}};
      end else if (f_iszero(fa)) begin
         a1_spec_in = '{hit: 1'b1, val: fb};
      end else if (f_iszero(fb)) begin
         a1_spec_in = '{hit: 1'b1, val: fa};
      end
   end

   // stage A2: magnitude add or subtract (big >= small by construction)
   rsq_spec_type a2_spec_ff;
   logic         a2_sign_ff;
   logic [7:0]   a2_exp_ff;
   logic [27:0]  a2_sum_ff, a2_sum_in;

   assign a2_sum_in = a1_sub_ff ? ({1'b0, a1_big_ff} - {1'b0, a1_small_ff})
                                : ({1'b0, a1_big_ff} + {1'b0, a1_small_ff});

   // stage A3: normalize; exact cancellation gives +0
   rsq_spec_type       a3_spec_ff, a3_spec_in;
   logic               a3_sign_ff;
   logic signed [10:0] a3_exp_ff, a3_exp_in;
   logic [27:0]        a3_sum_ff, a3_sum_in;
   logic [4:0]         lz;

   always_comb begin
      lz         = clz28(a2_sum_ff);
      a3_sum_in  = a2_sum_ff << lz;
      a3_exp_in  = $signed(11'(a2_exp_ff)) + 11'sd1 - $signed(11'(lz));
      a3_spec_in = a2_spec_ff;
      if (!a2_spec_ff.hit && a2_sum_ff == 28'd0) begin
         a3_spec_in = '{hit: 1'b1, val: 32'd0};
      end
   end

   // stage A4: round
   logic [31:0] a4_res_ff, a4_res_in;

   assign a4_res_in = a3_spec_ff.hit ? a3_spec_ff.val
                                     : rsq_round(a3_sign_ff, a3_exp_ff, {a3_sum_ff, 20'd0});

   always_ff @(posedge clock) begin
      if (en) begin
         a1_spec_ff  <= a1_spec_in;
         a1_sign_ff  <= a1_sign_in;
         a1_sub_ff   <= a1_sub_in;
         a1_exp_ff   <= a1_exp_in;
         a1_big_ff   <= a1_big_in;
         a1_small_ff <= a1_small_in;
         a2_spec_ff  <= a1_spec_ff;
         a2_sign_ff  <= a1_sign_ff;
         a2_exp_ff   <= a1_exp_ff;
         a2_sum_ff   <= a2_sum_in;
         a3_spec_ff  <= a3_spec_in;
         a3_sign_ff  <= a2_sign_ff;
         a3_exp_ff   <= a3_exp_in;
         a3_sum_ff   <= a3_sum_in;
         a4_res_ff   <= a4_res_in;
      end
   end

   assign u = a4_res_ff;

   // r = y * u; the multiplier's last stage is the output register.
   rsq_fmul u_mul_out (.clock(clock), .en(en), .a(y_ff[YD-1]), .b(u), .p(rsp_tdata));

endmodule

// ----- hw/rtl/rsq_checker.sv -----
// Port-level checker for the reciprocal square root pipeline, bound to the top level.
`timescale 1ns / 1ps
module rsq_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [31:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   // A held result stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp transaction changed while stalled");

   // Input side is open exactly when the output register can move.
   a_ready_rule: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("req_tready does not follow output stall");

   // Reset empties the pipe.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid after reset");

   // Any NaN produced is the default quiet NaN.
   a_qnan_only: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[30:23] == 8'hFF && rsp_tdata[22:0] != 23'd0
      |-> rsp_tdata == 32'h7FC0_0000)
      else $error("non-default NaN on rsp");

endmodule

bind fast_inverse_sqrt_float32 rsq_checker u_rsq_checker (
   .clock(clock),
   .reset(reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .req_tdata(req_tdata),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata)
);
